>>> hw/rtl/lwfp_pkg.sv
// Package for the wave front painter: field widths, register and operation codes,
// and the per-channel colour blend. Used by the interfaces, the painter core and the testbench.
// No dependencies.
package lwfp_pkg;

  localparam int unsigned ColorW  = 24;
  localparam int unsigned ElapsW  = 16;
  localparam int unsigned PixIdxW = 8;
  localparam int unsigned HeadW   = 8;
  localparam int unsigned PalW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;
  localparam int unsigned PalSlots = 4;

  localparam logic [0:0] OpTick = 1'b0;
  localparam logic [0:0] OpRead = 1'b1;

  localparam logic [CfgIdxW-1:0] RegDuration = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSpan     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCount    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegColor0   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegColor1   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegColor2   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegColor3   = 3'd6;

  function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] b, logic [15:0] w);
    logic [23:0] prod;
    logic [7:0]  res;
    if (b >= a) begin
      prod = 24'(b - a) * 24'(w);
      res  = a + prod[23:16];
    end else begin
      prod = 24'(a - b) * 24'(w);
      res  = a - prod[23:16];
    end
    return res;
  endfunction

  function automatic logic [ColorW-1:0] mix_color(logic [ColorW-1:0] c0,
                                                  logic [ColorW-1:0] c1,
                                                  logic [15:0] w);
    return {mix_channel(c0[23:16], c1[23:16], w),
            mix_channel(c0[15:8], c1[15:8], w),
            mix_channel(c0[7:0], c1[7:0], w)};
  endfunction

endpackage

>>> hw/rtl/lwfp_if.sv
// Handshake interfaces for the wave front painter: input items, result items
// and configuration writes. Depends on lwfp_pkg.
interface lwfp_in_if;
  logic                               valid;
  logic                               ready;
  logic [0:0]                         operation;
  logic [lwfp_pkg::ElapsW-1:0]        elapsed_ms;
  logic [lwfp_pkg::PixIdxW-1:0]       pixel_index;
  modport source (output valid, operation, elapsed_ms, pixel_index, input ready);
  modport sink (input valid, operation, elapsed_ms, pixel_index, output ready);
endinterface

interface lwfp_out_if;
  logic                               valid;
  logic                               ready;
  logic [lwfp_pkg::ColorW-1:0]        pixel_color;
  logic [lwfp_pkg::HeadW-1:0]         head_index;
  logic [lwfp_pkg::PalW-1:0]          palette_position;
  modport source (output valid, pixel_color, head_index, palette_position, input ready);
  modport sink (input valid, pixel_color, head_index, palette_position, output ready);
endinterface

interface lwfp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lwfp_pkg::CfgIdxW-1:0]       index;
  logic [lwfp_pkg::CfgDatW-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/lwfp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module lwfp_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/lwfp_div.sv
// Restoring divider producing one quotient bit per cycle.
// No dependencies.
module lwfp_div #(
  parameter int unsigned DivdW = 32,
  parameter int unsigned DivsW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivdW-1:0] dividend_i,
  input  logic [DivsW-1:0] divisor_i,
  output logic             done_o,
  output logic [DivdW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DivdW + 1);

  logic             run_q, run_d, done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivsW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DivdW-1:0] quo_q, quo_d;
  logic [DivsW:0]   shifted;
  logic [DivsW:0]   diff;

  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, quo_q[DivdW-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CntW'(DivdW);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[DivsW-1:0];
        quo_d = {quo_q[DivdW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DivsW-1:0];
        quo_d = {quo_q[DivdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hw/rtl/led_wave_front_painter_core.sv
// Wave front painter: a frame store of PIXEL_COUNT pixels is cleared to black by a
// sweep through every address after reset, during which no item is accepted. A read
// item wraps a large index by repeated subtraction of PIXEL_COUNT, then reads the
// frame store and presents the pixel. A tick mixes the current colour, reads the pixel
// ahead of the head, then paints pixel by pixel, skipping at most one pixel below the
// head, with a division for each blend weight, and ends with a division for the phase
// step. Both divisions use the shared serial divider, whose width is the larger of 32
// and clog2(PIXEL_COUNT+1)+24 (33 for 256 pixels). One item is worked at a time: the
// block is ready for the next item from the cycle in which a result is presented, and
// a result waits while an earlier result has not been taken.
// Depends on lwfp_pkg, lwfp_if, lwfp_ram and lwfp_div.
module led_wave_front_painter_core #(
  parameter int unsigned PIXEL_COUNT   = 256,
  parameter int unsigned PALETTE_DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  lwfp_in_if.sink    in_s,
  lwfp_out_if.source out_m,
  lwfp_cfg_if.sink   cfg_s
);

  localparam int unsigned AW   = $clog2(PIXEL_COUNT);
  localparam int unsigned NW   = $clog2(PIXEL_COUNT + 1);
  localparam int unsigned HW   = NW + 8;
  localparam int unsigned LW   = NW + 9;
  localparam int unsigned IW   = NW + 1;
  localparam int unsigned PRW  = NW + 16;
  localparam int unsigned DDW  = (NW + 24 > 32) ? NW + 24 : 32;
  localparam int unsigned SW   = (HW > 16) ? HW : 16;
  localparam int unsigned RW   = (NW > 8) ? NW : 8;
  localparam int unsigned CW   = lwfp_pkg::ColorW;

  typedef enum logic [12:0] {
    StClear  = 13'b0000000000001,
    StIdle   = 13'b0000000000010,
    StRMod   = 13'b0000000000100,
    StRAddr  = 13'b0000000001000,
    StRData  = 13'b0000000010000,
    StTSetup = 13'b0000000100000,
    StTRead  = 13'b0000001000000,
    StTAhead = 13'b0000010000000,
    StTCheck = 13'b0000100000000,
    StTDiv   = 13'b0001000000000,
    StTPaint = 13'b0010000000000,
    StTPhase = 13'b0100000000000,
    StDone   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [15:0]   dur_q, span_frac_q;
  logic [2:0]    count_q;
  logic [CW-1:0] pal_q [lwfp_pkg::PalSlots];
  logic [15:0]   phase_q, phase_d;
  logic [1:0]    pidx_q, pidx_d;

  // item and working registers
  logic [15:0]              elapsed_q;
  logic [RW-1:0]            rdx_q, rdx_d;
  logic [AW-1:0]            clr_q, clr_d;
  logic [CW-1:0]            cur_q, cur_d, ahead_q, ahead_d;
  logic [HW-1:0]            head_q, head_d, span_q, span_d;
  logic [LW-1:0]            last_q, last_d;
  logic [IW-1:0]            i_q, i_d;
  logic [AW-1:0]            pos_q, pos_d;
  logic [NW-1:0]            hint_q, hint_d;
  logic [15:0]              w_q, w_d;
  logic [CW-1:0]            res_col_q, res_col_d;
  logic [lwfp_pkg::HeadW-1:0] res_head_q, res_head_d;

  logic          ovalid_q, ovalid_d;
  logic [CW-1:0] ocol_q, ocol_d;
  logic [lwfp_pkg::HeadW-1:0] ohead_q, ohead_d;
  logic [1:0]    opal_q, opal_d;

  // combinational helpers
  logic [2:0]     live_cnt;
  logic [1:0]     nxt_idx;
  logic [PRW-1:0] head_prod, span_prod;
  logic [LW-1:0]  at;
  logic [NW:0]    ahead_sum;
  logic [AW-1:0]  ahead_addr;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [CW-1:0]  ram_wdata, ram_rdata;
  logic           div_start, div_done;
  logic [DDW-1:0] div_dividend, div_quo;
  logic [SW-1:0]  div_divisor;
  logic [DDW:0]   phase_sum;
  logic           cfg_we, in_acc;

  assign cfg_s.ready = 1'b1;
  assign cfg_we      = cfg_s.valid;
  assign in_s.ready  = (state_q == StIdle);
  assign in_acc      = in_s.valid && (state_q == StIdle);

  always_comb begin
    live_cnt = count_q;
    if (count_q == 3'd0) begin
      live_cnt = 3'd1;
    end else if (count_q > 3'(PALETTE_DEPTH)) begin
      live_cnt = 3'(PALETTE_DEPTH);
    end
  end

  // Reduction of the palette index for a newly written colour count.
  function automatic logic [1:0] reduce_idx(logic [1:0] idx, logic [2:0] cnt);
    logic [1:0] r;
    case (cnt)
      3'd1:    r = 2'd0;
      3'd2:    r = {1'b0, idx[0]};
      3'd3:    r = (idx == 2'd3) ? 2'd0 : idx;
      default: r = idx;
    endcase
    return r;
  endfunction

  logic [2:0] new_cnt;
  always_comb begin
    new_cnt = cfg_s.data[2:0];
    if (cfg_s.data[2:0] == 3'd0) begin
      new_cnt = 3'd1;
    end else if (cfg_s.data[2:0] > 3'(PALETTE_DEPTH)) begin
      new_cnt = 3'(PALETTE_DEPTH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q       <= 16'd1000;
      span_frac_q <= 16'd6554;
      count_q     <= 3'd2;
      pal_q[0]    <= 24'hFF0000;
      pal_q[1]    <= 24'h0000FF;
      pal_q[2]    <= 24'h000000;
      pal_q[3]    <= 24'h000000;
    end else if (cfg_we) begin
      unique case (cfg_s.index)
        lwfp_pkg::RegDuration: dur_q       <= cfg_s.data[15:0];
        lwfp_pkg::RegSpan:     span_frac_q <= cfg_s.data[15:0];
        lwfp_pkg::RegCount:    count_q     <= cfg_s.data[2:0];
        lwfp_pkg::RegColor0:   pal_q[0]    <= cfg_s.data;
        lwfp_pkg::RegColor1:   pal_q[1]    <= cfg_s.data;
        lwfp_pkg::RegColor2:   pal_q[2]    <= cfg_s.data;
        lwfp_pkg::RegColor3:   pal_q[3]    <= cfg_s.data;
        default: ;
      endcase
    end
  end

  assign nxt_idx    = (3'(pidx_q) + 3'd1 == live_cnt) ? 2'd0 : pidx_q + 2'd1;
  assign head_prod  = PRW'(PIXEL_COUNT) * PRW'(phase_q);
  assign span_prod  = PRW'(PIXEL_COUNT) * PRW'(span_frac_q);
  assign at         = LW'(i_q) << 8;
  assign ahead_sum  = (NW + 1)'(hint_q) + (NW + 1)'(1);
  assign ahead_addr = (ahead_sum == (NW + 1)'(PIXEL_COUNT)) ? '0 : ahead_sum[AW-1:0];
  assign phase_sum  = (DDW + 1)'(phase_q) + (DDW + 1)'(div_quo);

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    pidx_d       = pidx_q;
    rdx_d        = rdx_q;
    clr_d        = clr_q;
    cur_d        = cur_q;
    ahead_d      = ahead_q;
    head_d       = head_q;
    span_d       = span_q;
    last_d       = last_q;
    i_d          = i_q;
    pos_d        = pos_q;
    hint_d       = hint_q;
    w_d          = w_q;
    res_col_d    = res_col_q;
    res_head_d   = res_head_q;
    ovalid_d     = ovalid_q;
    ocol_d       = ocol_q;
    ohead_d      = ohead_q;
    opal_d       = opal_q;
    ram_we       = 1'b0;
    ram_waddr    = pos_q;
    ram_wdata    = lwfp_pkg::mix_color(ahead_q, cur_q, w_q);
    ram_raddr    = ahead_addr;
    div_start    = 1'b0;
    div_dividend = DDW'(LW'(at - LW'(head_q))) << 16;
    div_divisor  = SW'(span_q);

    if (ovalid_q && out_m.ready) begin
      ovalid_d = 1'b0;
    end
    if (cfg_we && (cfg_s.index == lwfp_pkg::RegCount)) begin
      pidx_d = reduce_idx(pidx_q, new_cnt);
    end

    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(PIXEL_COUNT - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_acc) begin
          rdx_d = RW'(in_s.pixel_index);
          state_d = (in_s.operation == lwfp_pkg::OpRead) ? StRMod : StTSetup;
        end
      end
      StRMod: begin
        // Wrap a read index beyond the pixel count, one subtraction a cycle.
        if (rdx_q >= RW'(PIXEL_COUNT)) begin
          rdx_d = rdx_q - RW'(PIXEL_COUNT);
        end else begin
          state_d = StRAddr;
        end
      end
      StRAddr: begin
        ram_raddr = rdx_q[AW-1:0];
        state_d   = StRData;
      end
      StRData: begin
        res_col_d  = ram_rdata;
        res_head_d = '0;
        state_d    = StDone;
      end
      StTSetup: begin
        cur_d   = lwfp_pkg::mix_color(pal_q[pidx_q], pal_q[nxt_idx], phase_q);
        head_d  = head_prod[PRW-1:8];
        span_d  = span_prod[PRW-1:8];
        hint_d  = head_prod[PRW-1:16];
        state_d = StTRead;
      end
      StTRead: begin
        last_d  = LW'(head_q) + LW'(span_q);
        i_d     = IW'(hint_q);
        pos_d   = hint_q[AW-1:0];
        state_d = StTAhead;
      end
      StTAhead: begin
        ahead_d = ram_rdata;
        state_d = StTCheck;
      end
      StTCheck: begin
        if (at < last_q) begin
          if ((at >= LW'(head_q)) && (span_q != '0)) begin
            div_start = 1'b1;
            state_d   = StTDiv;
          end else begin
            i_d = i_q + IW'(1);
          end
        end else begin
          div_start    = 1'b1;
          div_dividend = DDW'(elapsed_q) << 16;
          div_divisor  = (dur_q == 16'd0) ? SW'(1) : SW'(dur_q);
          state_d      = StTPhase;
        end
      end
      StTDiv: begin
        if (div_done) begin
          w_d     = div_quo[15:0];
          state_d = StTPaint;
        end
      end
      StTPaint: begin
        ram_we  = 1'b1;
        pos_d   = (pos_q == '0) ? AW'(PIXEL_COUNT - 1) : pos_q - AW'(1);
        i_d     = i_q + IW'(1);
        state_d = StTCheck;
      end
      StTPhase: begin
        if (div_done) begin
          phase_d = phase_sum[15:0];
          if (phase_sum[DDW:16] != '0) begin
            pidx_d = nxt_idx;
          end
          res_col_d  = cur_q;
          res_head_d = lwfp_pkg::HeadW'(hint_q);
          state_d    = StDone;
        end
      end
      StDone: begin
        if (!ovalid_q || out_m.ready) begin
          ovalid_d = 1'b1;
          ocol_d   = res_col_q;
          ohead_d  = res_head_q;
          opal_d   = pidx_q;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      clr_q    <= '0;
      phase_q  <= '0;
      pidx_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      phase_q  <= phase_d;
      pidx_q   <= pidx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      elapsed_q <= in_s.elapsed_ms;
    end
    rdx_q      <= rdx_d;
    cur_q      <= cur_d;
    ahead_q    <= ahead_d;
    head_q     <= head_d;
    span_q     <= span_d;
    last_q     <= last_d;
    i_q        <= i_d;
    pos_q      <= pos_d;
    hint_q     <= hint_d;
    w_q        <= w_d;
    res_col_q  <= res_col_d;
    res_head_q <= res_head_d;
    ocol_q     <= ocol_d;
    ohead_q    <= ohead_d;
    opal_q     <= opal_d;
  end

  lwfp_ram #(
    .Width (CW),
    .Depth (PIXEL_COUNT)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lwfp_div #(
    .DivdW (DDW),
    .DivsW (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_m.valid            = ovalid_q;
  assign out_m.pixel_color      = ocol_q;
  assign out_m.head_index       = ohead_q;
  assign out_m.palette_position = opal_q;

endmodule

>>> test/lwfp_checker.sv
// Checker for the wave front painter: watches the input, result and configuration
// channels, predicts every result item and compares it. Depends on lwfp_pkg, lwfp_if.
module lwfp_checker #(
  parameter int unsigned PIXEL_COUNT   = 256,
  parameter int unsigned PALETTE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lwfp_in_if.sink     in_w,
  lwfp_out_if.sink    out_w,
  lwfp_cfg_if.sink    cfg_w,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lwfp_pkg::ColorW-1:0] color;
    logic [lwfp_pkg::HeadW-1:0]  head;
    logic [lwfp_pkg::PalW-1:0]   pal;
  } wave_result_t;

  logic [15:0]                 sweep_ms;
  logic [15:0]                 span_q16;
  logic [2:0]                  hue_count;
  logic [lwfp_pkg::ColorW-1:0] hues [lwfp_pkg::PalSlots];
  logic [lwfp_pkg::ColorW-1:0] pixels [PIXEL_COUNT];
  logic [15:0]                 phase;
  logic [1:0]                  hue_pos;
  wave_result_t                awaited [$];
  int unsigned                 fails;

  assign fail_count_o = fails;
  assign pending_o    = awaited.size();

  function automatic logic [7:0] fade8(logic [7:0] a, logic [7:0] b, logic [15:0] w);
    logic [31:0] d;
    if (b >= a) begin
      d = ((32'(b) - 32'(a)) * 32'(w)) >> 16;
      return a + d[7:0];
    end
    d = ((32'(a) - 32'(b)) * 32'(w)) >> 16;
    return a - d[7:0];
  endfunction

  function automatic logic [lwfp_pkg::ColorW-1:0] fade(logic [lwfp_pkg::ColorW-1:0] c0,
                                                       logic [lwfp_pkg::ColorW-1:0] c1,
                                                       logic [15:0] w);
    return {fade8(c0[23:16], c1[23:16], w), fade8(c0[15:8], c1[15:8], w),
            fade8(c0[7:0], c1[7:0], w)};
  endfunction

  function automatic int unsigned hues_live();
    int unsigned n;
    n = 32'(hue_count);
    if (n < 1) n = 1;
    if (n > PALETTE_DEPTH) n = PALETTE_DEPTH;
    return n;
  endfunction

  task automatic paint_wave(input logic op, input logic [15:0] el, input logic [7:0] rd,
                            output wave_result_t r);
    int unsigned cnt, idx, nxt, head, span, hint, pos, i, at, dur, w;
    logic [lwfp_pkg::ColorW-1:0] cur, ahead;
    longint unsigned sum;
    if (op == lwfp_pkg::OpRead) begin
      r = '{pixels[rd % PIXEL_COUNT], '0, hue_pos};
      return;
    end
    cnt   = hues_live();
    idx   = hue_pos % cnt;
    nxt   = (idx + 1) % cnt;
    cur   = fade(hues[idx], hues[nxt], phase);
    head  = (PIXEL_COUNT * phase) >> 8;
    span  = (PIXEL_COUNT * span_q16) >> 8;
    hint  = head >> 8;
    ahead = pixels[(hint + 1) % PIXEL_COUNT];
    pos   = hint % PIXEL_COUNT;
    for (i = hint; (i << 8) < head + span; i++) begin
      at = i << 8;
      if (at >= head && span != 0) begin
        w = 32'((longint'(at - head) << 16) / span);
        pixels[pos] = fade(ahead, cur, w[15:0]);
        pos = (pos == 0) ? PIXEL_COUNT - 1 : pos - 1;
      end
    end
    dur = (sweep_ms == 0) ? 1 : 32'(sweep_ms);
    sum = longint'(phase) + ((longint'(el) << 16) / dur);
    if (sum >= 65536) hue_pos = 2'((idx + 1) % cnt);
    phase = sum[15:0];
    r = '{cur, hint[7:0], hue_pos};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wave_result_t r, got;
    if (!rst_ni) begin
      sweep_ms  = 16'd1000;
      span_q16  = 16'd6554;
      hue_count = 3'd2;
      hues[0]   = 24'hFF0000;
      hues[1]   = 24'h0000FF;
      hues[2]   = '0;
      hues[3]   = '0;
      foreach (pixels[k]) pixels[k] = '0;
      phase     = '0;
      hue_pos   = '0;
      awaited.delete();
      fails     = 0;
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_w.index)
          lwfp_pkg::RegDuration: sweep_ms = cfg_w.data[15:0];
          lwfp_pkg::RegSpan:     span_q16 = cfg_w.data[15:0];
          lwfp_pkg::RegCount: begin
            hue_count = cfg_w.data[2:0];
            hue_pos = 2'(hue_pos % hues_live());
          end
          lwfp_pkg::RegColor0, lwfp_pkg::RegColor1, lwfp_pkg::RegColor2,
          lwfp_pkg::RegColor3:
            hues[2'(cfg_w.index - lwfp_pkg::RegColor0)] = cfg_w.data;
          default: ;
        endcase
      end
      if (out_w.valid && out_w.ready) begin
        got = '{out_w.pixel_color, out_w.head_index, out_w.palette_position};
        if (awaited.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result item %h", got);
        end else begin
          r = awaited.pop_front();
          if (got !== r) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: colour %h/%h head %h/%h palette %h/%h (expected/actual)",
                       r.color, got.color, r.head, got.head, r.pal, got.pal);
          end
        end
      end
      if (in_w.valid && in_w.ready) begin
        paint_wave(in_w.operation, in_w.elapsed_ms, in_w.pixel_index, r);
        awaited = {awaited, r};
      end
    end
  end
endmodule

>>> test/tb_top.sv
// Testbench top for the wave front painter: drives register writes, items with random gaps
// and result stalls, gives the verdict. Depends on lwfp_pkg, lwfp_if, lwfp_checker, the core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count, pending;
  longint unsigned cycle_count = 0;
  logic        hold_off = 1'b0;
  bit          feeding_done = 1'b0;

  lwfp_in_if  in_c ();
  lwfp_out_if out_c ();
  lwfp_cfg_if cfg_c ();

  led_wave_front_painter_core i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_s(in_c), .out_m(out_c), .cfg_s(cfg_c));

  lwfp_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_w(in_c), .out_w(out_c), .cfg_w(cfg_c),
    .fail_count_o(fail_count), .pending_o(pending));

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    in_c.valid = 1'b0; in_c.operation = lwfp_pkg::OpTick; in_c.elapsed_ms = '0;
    in_c.pixel_index = '0;
    cfg_c.valid = 1'b0; cfg_c.index = lwfp_pkg::RegDuration; cfg_c.data = '0;
    out_c.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd20000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stall per item, plus a long hold-off when asked.
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 4);
      repeat (gap) @(posedge clk_i);
      while (hold_off) @(posedge clk_i);
      out_c.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_c.valid) @(posedge clk_i);
      out_c.ready <= 1'b0;
    end
  end

  task automatic write_reg(input logic [lwfp_pkg::CfgIdxW-1:0] idx,
                           input logic [lwfp_pkg::CfgDatW-1:0] val);
    cfg_c.valid <= 1'b1;
    cfg_c.index <= idx;
    cfg_c.data  <= val;
    @(posedge clk_i);
    while (!cfg_c.ready) @(posedge clk_i);
    cfg_c.valid <= 1'b0;
  endtask

  task automatic send_item(input logic op, input logic [15:0] el, input logic [7:0] px,
                           input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    repeat (gap) @(posedge clk_i);
    in_c.valid       <= 1'b1;
    in_c.operation   <= op;
    in_c.elapsed_ms  <= el;
    in_c.pixel_index <= px;
    @(posedge clk_i);
    while (!in_c.ready) @(posedge clk_i);
    in_c.valid <= 1'b0;
  endtask

  // Waits until every expected result has arrived and the block has settled.
  // The first edge lets the checker record an item accepted at the previous edge.
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_item();
    logic [15:0] el;
    case ($urandom_range(0, 5))
      0:       el = 16'($urandom);
      1:       el = 16'($urandom_range(0, 3));
      default: el = 16'($urandom_range(0, 400));
    endcase
    send_item(($urandom_range(0, 3) == 0) ? lwfp_pkg::OpRead : lwfp_pkg::OpTick, el,
              8'($urandom), 1'b0);
  endtask

  initial begin
    int unsigned k, ph;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: defaults, extremes, reads beyond any painted pixel.
    send_item(lwfp_pkg::OpRead, 16'd0, 8'd0, 1'b0);
    send_item(lwfp_pkg::OpRead, 16'd0, 8'd255, 1'b0);
    send_item(lwfp_pkg::OpTick, 16'd0, 8'd0, 1'b0);
    send_item(lwfp_pkg::OpTick, 16'd500, 8'd0, 1'b0);
    send_item(lwfp_pkg::OpTick, 16'd499, 8'd0, 1'b0);
    send_item(lwfp_pkg::OpTick, 16'd1, 8'd0, 1'b0);
    send_item(lwfp_pkg::OpTick, 16'hFFFF, 8'hFF, 1'b0);
    send_item(lwfp_pkg::OpRead, 16'hFFFF, 8'd1, 1'b0);
    drain();
    write_reg(lwfp_pkg::RegDuration, 24'd0);   // zero duration acts as one
    write_reg(lwfp_pkg::RegSpan, 24'd0);       // empty span
    write_reg(lwfp_pkg::RegCount, 24'd0);
    write_reg(lwfp_pkg::RegColor0, 24'hFFFFFF);
    write_reg(lwfp_pkg::RegColor1, 24'h000000);
    write_reg(lwfp_pkg::RegColor2, 24'h00FF00);
    write_reg(lwfp_pkg::RegColor3, 24'hABCDEF);
    write_reg(3'd7, 24'hFFFFFF);     // unknown index, ignored
    send_item(lwfp_pkg::OpTick, 16'd1, 8'd0, 1'b0);
    send_item(lwfp_pkg::OpTick, 16'd0, 8'd0, 1'b0);
    send_item(lwfp_pkg::OpRead, 16'd0, 8'd128, 1'b0);
    drain();
    write_reg(lwfp_pkg::RegDuration, 24'd65535);
    write_reg(lwfp_pkg::RegSpan, 24'd65535);
    write_reg(lwfp_pkg::RegCount, 24'd7);
    send_item(lwfp_pkg::OpTick, 16'd32768, 8'd0, 1'b0);
    send_item(lwfp_pkg::OpTick, 16'd65535, 8'd0, 1'b0);
    send_item(lwfp_pkg::OpTick, 16'd40000, 8'd0, 1'b0);
    send_item(lwfp_pkg::OpRead, 16'd0, 8'd200, 1'b0);
    drain();
    // Random phases with varied settings.
    for (ph = 0; ph < 6; ph++) begin
      write_reg(lwfp_pkg::RegDuration, 24'($urandom_range(1, 2000)));
      write_reg(lwfp_pkg::RegSpan, (ph == 5) ? 24'd65535 : 24'($urandom_range(0, 20000)));
      write_reg(lwfp_pkg::RegCount, 24'($urandom_range(0, 7)));
      for (k = 0; k < 4; k++) write_reg(lwfp_pkg::RegColor0 + 3'(k), 24'($urandom));
      if (ph == 2) begin
        hold_off <= 1'b1;
        fork
          begin
            repeat (600) @(posedge clk_i);
            hold_off <= 1'b0;
          end
        join_none
      end
      for (k = 0; k < 150; k++) random_item();
      if (ph == 3) begin
        drain();  // sender pauses until all results are in
        for (k = 0; k < 10; k++)
          send_item(lwfp_pkg::OpTick, 16'($urandom_range(0, 200)), 8'd0, 1'b1);
      end
      drain();
    end
    feeding_done = 1'b1;
  end

  initial begin
    wait (feeding_done);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
